// ----- src/jlcc_pkg.sv -----
// ----------------------------------------------------------------------------
// jlcc_pkg: shared types and constants for the JSteg LSB coefficient codec
// Holds the counter width, register indexes, and the result beat layout.
// ----------------------------------------------------------------------------
package jlcc_pkg;

    // Bit counter is wide enough for a 32-bit header plus 2^32 bytes of payload.
    localparam int CNT_W     = 36;
    localparam int BYTE_BITS = 8;
    localparam int BPOS_W    = 3;
    localparam int REG_W     = 32;

    // Register indexes on the configuration port.
    localparam logic REG_MODE           = 1'b0;
    localparam logic REG_PAYLOAD_LENGTH = 1'b1;

    // Mode codes.
    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // Result beat, minus the coefficient, which follows COEF_WIDTH.
    typedef struct packed {
        logic                 carried;
        logic                 byte_consumed;
        logic                 byte_valid;
        logic [BYTE_BITS-1:0] byte_out;
        logic                 done_res;
    } jlcc_flags_t;

endpackage

// ----- src/jsteg_lsb_coefficient_codec_top.sv -----
// ----------------------------------------------------------------------------
// jsteg_lsb_coefficient_codec_top: JSteg LSB embed / extract on DCT coefficients
//
// Input channel (s_*): one quantized coefficient per beat, with the payload
// byte currently offered and a restart flag that clears the counters before
// that coefficient. Result channel (m_*): the coefficient (LSB replaced in
// embed mode), carried / byte_consumed / byte_valid / byte_out / done_res.
// Coefficients equal to 0 or 1 carry no bit. A 32-bit length header goes
// first (LSB first), then payload bytes MSB first.
//
// A beat passes an input register, then one pass of compare / counter step /
// bit mux into the result register. Throughput is one beat per cycle while
// results are taken; the input register may take a beat while a result waits in
// the output register. When the receiver stalls, the result holds and one
// more beat is taken into the input register, after which s_ready drops until
// the result is taken. Reset clears mode, payload_length and all counters;
// both stages go empty. The APB port (mode at 0x0, payload_length at 0x4)
// is to be written by the user while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module jsteg_lsb_coefficient_codec_top
    import jlcc_pkg::*;
#(
    parameter int COEF_WIDTH  = 16,
    parameter int HEADER_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COEF_WIDTH-1:0] s_coefficient,
    input  logic [BYTE_BITS-1:0]         s_payload_byte,
    input  logic                         s_restart,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COEF_WIDTH-1:0] m_coefficient_out,
    output logic                         m_carried,
    output logic                         m_byte_consumed,
    output logic                         m_byte_valid,
    output logic [BYTE_BITS-1:0]         m_byte_out,
    output logic                         m_done_res,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [REG_W-1:0]             pwdata,
    output logic [REG_W-1:0]             prdata,
    output logic                         pready
);

    localparam int HDR_IDX_W = $clog2(HEADER_BITS);

    // Configuration registers
    logic             mode_reg;
    logic [REG_W-1:0] payload_length_reg;

    // Codec state
    logic [CNT_W-1:0]       bit_counter_reg,   bit_counter_next;
    logic [HEADER_BITS-1:0] header_length_reg, header_length_next;
    logic [BYTE_BITS-1:0]   byte_shift_reg,    byte_shift_next;
    logic [BPOS_W-1:0]      bit_position_reg,  bit_position_next;
    logic                   finished_reg,      finished_next;

    // Input stage
    logic                  in_valid_reg;
    logic [COEF_WIDTH-1:0] in_coef_reg;
    logic [BYTE_BITS-1:0]  in_byte_reg;
    logic                  in_restart_reg;

    // Result stage
    logic                  out_valid_reg;
    logic [COEF_WIDTH-1:0] out_coef_reg, out_coef_next;
    jlcc_flags_t           out_flags_reg, out_flags_next;

    logic advance;
    logic cfg_write;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_MODE:           prdata = {{(REG_W-1){1'b0}}, mode_reg};
            REG_PAYLOAD_LENGTH: prdata = payload_length_reg;
            default:            prdata = '0;
        endcase
    end

    // Number of message bits for the current mode; all ones while the
    // extract header is still being read.
    function automatic logic [CNT_W-1:0] total_bits(
        input logic                   md,
        input logic [HEADER_BITS-1:0] hdr_len,
        input logic [HEADER_BITS-1:0] cfg_len,
        input logic [CNT_W-1:0]       cnt
    );
        logic [HEADER_BITS-1:0] len;
        logic [CNT_W-1:0]       result;
        len = (md == MODE_EXTRACT) ? hdr_len : cfg_len;
        if (md == MODE_EXTRACT && cnt < CNT_W'(HEADER_BITS)) begin
            result = '1;
        end else begin
            result = CNT_W'(HEADER_BITS) + CNT_W'({len, 3'b000});
        end
        return result;
    endfunction

    always_comb begin
        logic [CNT_W-1:0]       cnt0;
        logic [HEADER_BITS-1:0] hdr0;
        logic [BYTE_BITS-1:0]   shift0;
        logic [BPOS_W-1:0]      pos0;
        logic                   fin0;
        logic                   in_header;
        logic                   msg_bit;
        logic [BYTE_BITS-1:0]   shifted;
        logic [HEADER_BITS-1:0] cfg_len;

        cfg_len = payload_length_reg[HEADER_BITS-1:0];

        // restart clears the state ahead of this coefficient
        if (in_restart_reg) begin
            cnt0   = '0;
            hdr0   = '0;
            shift0 = '0;
            pos0   = '0;
            fin0   = 1'b0;
        end else begin
            cnt0   = bit_counter_reg;
            hdr0   = header_length_reg;
            shift0 = byte_shift_reg;
            pos0   = bit_position_reg;
            fin0   = finished_reg;
        end

        // a register change may already put the count past the total
        fin0 = fin0 || (cnt0 >= total_bits(mode_reg, hdr0, cfg_len, cnt0));

        bit_counter_next   = cnt0;
        header_length_next = hdr0;
        byte_shift_next    = shift0;
        bit_position_next  = pos0;
        finished_next      = fin0;

        out_coef_next  = in_coef_reg;
        out_flags_next = '0;
        in_header      = cnt0 < CNT_W'(HEADER_BITS);
        msg_bit        = 1'b0;
        shifted        = '0;

        if (in_coef_reg != '0 && in_coef_reg != {{(COEF_WIDTH-1){1'b0}}, 1'b1} && !fin0) begin
            out_flags_next.carried = 1'b1;
            if (mode_reg == MODE_EMBED) begin
                if (in_header) begin
                    msg_bit = cfg_len[cnt0[HDR_IDX_W-1:0]];
                end else begin
                    msg_bit = in_byte_reg[3'd7 - pos0];
                    out_flags_next.byte_consumed = (pos0 == 3'd7);
                    bit_position_next = pos0 + 3'd1;
                end
                out_coef_next = {in_coef_reg[COEF_WIDTH-1:1], msg_bit};
            end else begin
                msg_bit = in_coef_reg[0];
                if (in_header) begin
                    header_length_next[cnt0[HDR_IDX_W-1:0]] = msg_bit;
                end else begin
                    shifted = {shift0[BYTE_BITS-2:0], msg_bit};
                    bit_position_next = pos0 + 3'd1;
                    // byte complete when the position wraps
                    if (bit_position_next == '0) begin
                        out_flags_next.byte_valid = 1'b1;
                        out_flags_next.byte_out   = shifted;
                        byte_shift_next           = '0;
                    end else begin
                        byte_shift_next = shifted;
                    end
                end
            end
            bit_counter_next = cnt0 + CNT_W'(1);
            finished_next = fin0 || (bit_counter_next >=
                total_bits(mode_reg, header_length_next, cfg_len, bit_counter_next));
        end

        out_flags_next.done_res = finished_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= MODE_EMBED;
            payload_length_reg <= '0;
            bit_counter_reg    <= '0;
            header_length_reg  <= '0;
            byte_shift_reg     <= '0;
            bit_position_reg   <= '0;
            finished_reg       <= 1'b0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (paddr[2])
                    REG_MODE:           mode_reg <= pwdata[0];
                    REG_PAYLOAD_LENGTH: payload_length_reg <= pwdata;
                    default:            mode_reg <= mode_reg;
                endcase
            end

            // take a new beat whenever the input stage empties or is empty
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            if (advance) begin
                bit_counter_reg   <= bit_counter_next;
                header_length_reg <= header_length_next;
                byte_shift_reg    <= byte_shift_next;
                bit_position_reg  <= bit_position_next;
                finished_reg      <= finished_next;
                out_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg     <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_coef_reg    <= s_coefficient;
            in_byte_reg    <= s_payload_byte;
            in_restart_reg <= s_restart;
        end
        if (advance) begin
            out_coef_reg  <= out_coef_next;
            out_flags_reg <= out_flags_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_coefficient_out = out_coef_reg;
    assign m_carried         = out_flags_reg.carried;
    assign m_byte_consumed   = out_flags_reg.byte_consumed;
    assign m_byte_valid      = out_flags_reg.byte_valid;
    assign m_byte_out        = out_flags_reg.byte_out;
    assign m_done_res        = out_flags_reg.done_res;

endmodule
